### rtl/image_stripe_mean_corrector_macros.svh
// Assertion macros shared by the stripe mean corrector RTL.
// Depends on signals clk and rst_n in the module that uses them.
`ifndef IMAGE_STRIPE_MEAN_CORRECTOR_MACROS_SVH
`define IMAGE_STRIPE_MEAN_CORRECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ISC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ISC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ISC_ASSERT_IMP(lbl, ante, cons, msg)
`define ISC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/isc_pkg.sv
// Package for the stripe mean corrector: payload words, codes, state and
// command/status types. No dependencies.
`default_nettype none

package isc_pkg;

    localparam int PIX_FIELD_W    = 16;
    localparam int OUT_VALUE_W    = 32;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_PIXEL_BITS = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDE_MODE = 2'd0,
        CFG_ROW_STRIPES = 2'd1,
        CFG_ROWS_IN_USE = 2'd2,
        CFG_COLS_IN_USE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                   command;
        logic [PIX_FIELD_W-1:0] pixel_value;
        logic                   pixel_null;
    } isc_in_t;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] corrected_value;
        logic                          corrected_null;
        logic                          last_pixel;
    } isc_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_UPD,
        S_MEAN_RD,
        S_MEAN_CHK,
        S_MEAN_WAIT,
        S_TOTAL,
        S_TOTAL_WAIT,
        S_READ_LAT,
        S_READ_DEC,
        S_READ_MUL,
        S_READ_DIV,
        S_READ_WAIT
    } isc_state_t;

    typedef enum logic {
        PH_LOAD,
        PH_READ
    } phase_t;

    typedef enum logic [1:0] {
        DIV_SRC_STRIPE,
        DIV_SRC_TOTAL,
        DIV_SRC_READ
    } div_src_t;

    typedef enum logic [1:0] {
        OUT_SRC_NULL,
        OUT_SRC_SUB,
        OUT_SRC_PASS,
        OUT_SRC_DIV
    } out_src_t;

    typedef struct packed {
        logic     idx_clr;
        logic     idx_inc;
        logic     sc_rd_idx;
        logic     sc_zero_wr;
        logic     load_acc;
        logic     load_upd;
        logic     avg_wr_zero;
        logic     avg_wr_div;
        logic     div_start;
        div_src_t div_sel;
        logic     total_wr;
        logic     read_acc;
        logic     read_lat;
        logic     read_mul;
        logic     out_load;
        out_src_t out_src;
        logic     accum_clr;
    } isc_cmd_t;

    typedef struct packed {
        logic load_last;
        logic read_last;
        logic idx_last_stripe;
        logic idx_last_clear;
        logic cnt_zero;
        logic tcnt_zero;
        logic div_done;
        logic div_busy;
        logic pix_null;
        logic sm_zero;
        logic out_full;
        logic divide_mode;
    } isc_status_t;

endpackage

`default_nettype wire

### rtl/isc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module isc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/isc_div.sv
// Restoring divider, one quotient bit per cycle, quotient held until restart.
// No package dependencies.
`default_nettype none

module isc_div #(
    parameter int NW = 56,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      trial;
    logic             ge;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = CNT_W'(32'(cnt_reg) + 1);
            if (32'(cnt_reg) == NW - 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

### rtl/isc_datapath.sv
// Datapath: image and stripe memories, counters, accumulators, divider and
// output register. Depends on isc_pkg, isc_ram and isc_div.
`default_nettype none

module isc_datapath
    import isc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  isc_cmd_t              cmd,
    input  isc_in_t               in_data,
    input  logic                  divide_mode,
    input  logic                  row_stripes,
    input  logic [CFG_DATA_W-1:0] rows_in_use,
    input  logic [CFG_DATA_W-1:0] cols_in_use,
    output isc_status_t           status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output isc_out_t              out_data
);

    localparam int PW       = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
    localparam int NPIX     = MAX_ROWS * MAX_COLS;
    localparam int NSTRIPES = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int AW       = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int SW       = (NSTRIPES > 1) ? $clog2(NSTRIPES) : 1;
    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RDW      = $clog2(MAX_ROWS + 1);
    localparam int CDW      = $clog2(MAX_COLS + 1);
    localparam int SCNT_W   = $clog2(NSTRIPES + 1);
    localparam int SSUM_W   = PW + SCNT_W;
    localparam int SC_W     = SSUM_W + SCNT_W;
    localparam int TCNT_W   = $clog2(NPIX + 1);
    localparam int TSUM_W   = PW + TCNT_W;
    localparam int MNUM_W   = TSUM_W + 16;
    localparam int RNUM_W   = PW + 40;
    localparam int NW       = (MNUM_W > RNUM_W) ? MNUM_W : RNUM_W;
    localparam int DW       = (TCNT_W > 32) ? TCNT_W : 32;
    localparam int XW       = (((PW + 16) > 32) ? (PW + 16) : 32) + 2;
    localparam logic signed [XW-1:0] SAT_MAX = XW'(64'h7FFF_FFFF);
    localparam logic signed [XW-1:0] SAT_MIN = ~SAT_MAX;

    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int maxv);
        int r;
        r = int'(v);
        if (r == 0)
        begin
            r = 1;
        end
        else if (r > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    // latched geometry
    logic [RDW-1:0] act_rows_reg;
    logic [CDW-1:0] act_cols_reg;
    logic           act_rowmode_reg;
    // raster position, shared by load and readout
    logic [AW-1:0]  pos_reg, pos_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [SW-1:0]  idx_reg;
    // totals
    logic [TSUM_W-1:0] tsum_reg;
    logic [TCNT_W-1:0] tcnt_reg;
    logic [31:0]       gmean_reg;
    // load word
    logic [PW-1:0]  ld_val_reg;
    logic           ld_null_reg;
    logic [SW-1:0]  ld_stripe_reg;
    logic           ld_last_reg;
    // readout word
    logic [PW-1:0]    pv_reg;
    logic             pnull_reg;
    logic [31:0]      sm_reg;
    logic [PW+31:0]   mul_reg;
    logic             out_valid_reg;
    isc_out_t         out_data_reg;

    logic [RDW-1:0] g_rows;
    logic [CDW-1:0] g_cols;
    logic           g_rowmode;
    logic           first_load;
    logic           cur_last;
    logic [SW-1:0]  stripe_cur;

    logic              img_we;
    logic [PW:0]       img_wdata, img_rdata;
    logic              sc_we, sc_re;
    logic [SW-1:0]     sc_waddr, sc_raddr;
    logic [SC_W-1:0]   sc_wdata, sc_rdata;
    logic [SSUM_W-1:0] sc_rd_sum;
    logic [SCNT_W-1:0] sc_rd_cnt;
    logic              avg_we;
    logic [31:0]       avg_wdata, avg_rdata;

    logic [NW-1:0]  div_num, div_quot;
    logic [DW-1:0]  div_den;
    logic           div_busy, div_done;
    logic [31:0]    mean_sat, rdiv_sat;

    logic [XW-1:0]        sub_x, sub_r;
    logic signed [XW-1:0] sub_q;
    logic [31:0]          sub_val;
    logic [31:0]          out_val;

    // geometry in force: config on the first load of an image
    assign first_load = cmd.load_acc && (pos_reg == '0);
    assign g_rows     = first_load ? RDW'(clamp_dim(rows_in_use, MAX_ROWS)) : act_rows_reg;
    assign g_cols     = first_load ? CDW'(clamp_dim(cols_in_use, MAX_COLS)) : act_cols_reg;
    assign g_rowmode  = first_load ? row_stripes : act_rowmode_reg;
    assign cur_last   = (32'(row_reg) + 1 == 32'(g_rows)) && (32'(col_reg) + 1 == 32'(g_cols));
    assign stripe_cur = g_rowmode ? SW'(row_reg) : SW'(col_reg);

    // raster advance
    always_comb
    begin
        pos_next = pos_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.load_upd || cmd.out_load)
        begin
            if (cur_last)
            begin
                pos_next = '0;
                row_next = '0;
                col_next = '0;
            end
            else
            begin
                pos_next = AW'(32'(pos_reg) + 1);
                if (32'(col_reg) + 1 == 32'(g_cols))
                begin
                    col_next = '0;
                    row_next = RW'(32'(row_reg) + 1);
                end
                else
                begin
                    col_next = CW'(32'(col_reg) + 1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_rows_reg    <= RDW'(clamp_dim(9'd256, MAX_ROWS));
            act_cols_reg    <= CDW'(clamp_dim(9'd256, MAX_COLS));
            act_rowmode_reg <= 1'b0;
            pos_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            idx_reg         <= '0;
            tsum_reg        <= '0;
            tcnt_reg        <= '0;
            gmean_reg       <= '0;
            ld_last_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
            col_reg <= col_next;
            if (first_load)
            begin
                act_rows_reg    <= g_rows;
                act_cols_reg    <= g_cols;
                act_rowmode_reg <= g_rowmode;
            end
            if (cmd.load_acc)
            begin
                ld_last_reg <= cur_last;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= SW'(32'(idx_reg) + 1);
            end
            if (cmd.accum_clr)
            begin
                tsum_reg  <= '0;
                tcnt_reg  <= '0;
                gmean_reg <= '0;
            end
            else
            begin
                if (cmd.load_upd && !ld_null_reg)
                begin
                    tsum_reg <= tsum_reg + TSUM_W'(ld_val_reg);
                    tcnt_reg <= TCNT_W'(32'(tcnt_reg) + 1);
                end
                if (cmd.total_wr)
                begin
                    gmean_reg <= mean_sat;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_acc)
        begin
            ld_val_reg    <= in_data.pixel_value[PW-1:0];
            ld_null_reg   <= in_data.pixel_null;
            ld_stripe_reg <= stripe_cur;
        end
        if (cmd.read_lat)
        begin
            pv_reg    <= img_rdata[PW-1:0];
            pnull_reg <= img_rdata[PW];
            sm_reg    <= avg_rdata;
        end
        if (cmd.read_mul)
        begin
            mul_reg <= (PW + 32)'(pv_reg) * (PW + 32)'(gmean_reg);
        end
        if (cmd.out_load)
        begin
            out_data_reg.corrected_value <= out_val;
            out_data_reg.corrected_null  <= (cmd.out_src == OUT_SRC_NULL);
            out_data_reg.last_pixel      <= cur_last;
        end
    end

    // image store
    assign img_we    = cmd.load_acc;
    assign img_wdata = in_data.pixel_null ? {1'b1, PW'(0)} : {1'b0, in_data.pixel_value[PW-1:0]};

    isc_ram #(
        .WIDTH (PW + 1),
        .DEPTH (NPIX)
    ) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (pos_reg),
        .wdata (img_wdata),
        .re    (cmd.read_acc),
        .raddr (pos_reg),
        .rdata (img_rdata)
    );

    // stripe sum and count store
    assign sc_rd_sum = sc_rdata[SC_W-1:SCNT_W];
    assign sc_rd_cnt = sc_rdata[SCNT_W-1:0];
    assign sc_we     = cmd.sc_zero_wr || cmd.load_upd;
    assign sc_waddr  = cmd.load_upd ? ld_stripe_reg : idx_reg;
    assign sc_re     = cmd.load_acc || cmd.sc_rd_idx;
    assign sc_raddr  = cmd.load_acc ? stripe_cur : idx_reg;

    always_comb
    begin
        sc_wdata = '0;
        if (cmd.load_upd)
        begin
            if (ld_null_reg)
            begin
                sc_wdata = sc_rdata;
            end
            else
            begin
                sc_wdata = {sc_rd_sum + SSUM_W'(ld_val_reg), SCNT_W'(32'(sc_rd_cnt) + 1)};
            end
        end
    end

    isc_ram #(
        .WIDTH (SC_W),
        .DEPTH (NSTRIPES)
    ) u_sc_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .re    (sc_re),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

    // stripe mean store
    assign avg_we    = cmd.avg_wr_zero || cmd.avg_wr_div;
    assign avg_wdata = cmd.avg_wr_div ? mean_sat : 32'd0;

    isc_ram #(
        .WIDTH (32),
        .DEPTH (NSTRIPES)
    ) u_avg_ram (
        .clk   (clk),
        .we    (avg_we),
        .waddr (idx_reg),
        .wdata (avg_wdata),
        .re    (cmd.read_acc),
        .raddr (stripe_cur),
        .rdata (avg_rdata)
    );

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SRC_STRIPE:
            begin
                div_num = NW'({sc_rd_sum, 16'b0});
                div_den = DW'(sc_rd_cnt);
            end
            DIV_SRC_TOTAL:
            begin
                div_num = NW'({tsum_reg, 16'b0});
                div_den = DW'(tcnt_reg);
            end
            DIV_SRC_READ:
            begin
                div_num = NW'({mul_reg, 8'b0});
                div_den = DW'(sm_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    isc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // saturate quotients: unsigned Q16.16 mean, signed Q23.8 ratio
    assign mean_sat = (|div_quot[NW-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
    assign rdiv_sat = (|div_quot[NW-1:31]) ? 32'h7FFF_FFFF : div_quot[31:0];

    // subtract mode, truncate toward zero then saturate
    always_comb
    begin
        sub_x = XW'({pv_reg, 16'b0}) - XW'(sm_reg) + XW'(gmean_reg);
        sub_r = sub_x + (sub_x[XW-1] ? XW'(255) : XW'(0));
        sub_q = $signed(sub_r) >>> 8;
        if (sub_q > SAT_MAX)
        begin
            sub_val = 32'h7FFF_FFFF;
        end
        else if (sub_q < SAT_MIN)
        begin
            sub_val = 32'h8000_0000;
        end
        else
        begin
            sub_val = sub_q[31:0];
        end
    end

    // result select
    always_comb
    begin
        case (cmd.out_src)
            OUT_SRC_NULL: out_val = 32'd0;
            OUT_SRC_SUB:  out_val = sub_val;
            OUT_SRC_PASS: out_val = 32'({pv_reg, 8'b0});
            OUT_SRC_DIV:  out_val = rdiv_sat;
            default:      out_val = 32'd0;
        endcase
    end

    // status to controller
    always_comb
    begin
        status.load_last       = ld_last_reg;
        status.read_last       = cur_last;
        status.idx_last_stripe = (32'(idx_reg) + 1 ==
                                  (act_rowmode_reg ? 32'(act_rows_reg) : 32'(act_cols_reg)));
        status.idx_last_clear  = (32'(idx_reg) + 1 == NSTRIPES);
        status.cnt_zero        = (sc_rd_cnt == '0);
        status.tcnt_zero       = (tcnt_reg == '0);
        status.div_done        = div_done;
        status.div_busy        = div_busy;
        status.pix_null        = pnull_reg;
        status.sm_zero         = (sm_reg == 32'd0);
        status.out_full        = out_valid_reg;
        status.divide_mode     = divide_mode;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/isc_ctrl.sv
// Controller state machine: sequences load, mean, readout and clearing pass.
// Depends on isc_pkg and the assertion macro header.
`default_nettype none
`include "image_stripe_mean_corrector_macros.svh"

module isc_ctrl
    import isc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_command,
    output logic        in_stall,
    input  isc_status_t status,
    output isc_cmd_t    cmd
);

    isc_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE) || status.out_full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SRC_STRIPE;
        cmd.out_src = OUT_SRC_NULL;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sc_zero_wr = 1'b1;
                if (status.idx_last_clear)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_command == CMD_LOAD && phase_reg == PH_LOAD)
                    begin
                        cmd.load_acc = 1'b1;
                        state_next   = S_LOAD_UPD;
                    end
                    else if (in_command == CMD_READ && phase_reg == PH_READ)
                    begin
                        cmd.read_acc = 1'b1;
                        state_next   = S_READ_LAT;
                    end
                end
            end
            S_LOAD_UPD:
            begin
                cmd.load_upd = 1'b1;
                if (status.load_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_MEAN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MEAN_RD:
            begin
                cmd.sc_rd_idx = 1'b1;
                state_next    = S_MEAN_CHK;
            end
            S_MEAN_CHK:
            begin
                // stripe entry is cleared for the next image as it is read
                cmd.sc_zero_wr = 1'b1;
                if (status.cnt_zero)
                begin
                    cmd.avg_wr_zero = 1'b1;
                    if (status.idx_last_stripe)
                    begin
                        state_next = S_TOTAL;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_MEAN_RD;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SRC_STRIPE;
                    state_next    = S_MEAN_WAIT;
                end
            end
            S_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.avg_wr_div = 1'b1;
                    if (status.idx_last_stripe)
                    begin
                        state_next = S_TOTAL;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_MEAN_RD;
                    end
                end
            end
            S_TOTAL:
            begin
                // empty image keeps the cleared global mean
                if (status.tcnt_zero)
                begin
                    phase_next = PH_READ;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SRC_TOTAL;
                    state_next    = S_TOTAL_WAIT;
                end
            end
            S_TOTAL_WAIT:
            begin
                cmd.div_sel = DIV_SRC_TOTAL;
                if (status.div_done)
                begin
                    cmd.total_wr = 1'b1;
                    phase_next   = PH_READ;
                    state_next   = S_IDLE;
                end
            end
            S_READ_LAT:
            begin
                cmd.read_lat = 1'b1;
                state_next   = S_READ_DEC;
            end
            S_READ_DEC:
            begin
                if (status.pix_null || !status.divide_mode || status.sm_zero)
                begin
                    cmd.out_load = 1'b1;
                    if (status.pix_null)
                    begin
                        cmd.out_src = OUT_SRC_NULL;
                    end
                    else if (!status.divide_mode)
                    begin
                        cmd.out_src = OUT_SRC_SUB;
                    end
                    else
                    begin
                        cmd.out_src = OUT_SRC_PASS;
                    end
                    if (status.read_last)
                    begin
                        cmd.accum_clr = 1'b1;
                        phase_next    = PH_LOAD;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ_MUL;
                end
            end
            S_READ_MUL:
            begin
                cmd.read_mul = 1'b1;
                state_next   = S_READ_DIV;
            end
            S_READ_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SRC_READ;
                state_next    = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OUT_SRC_DIV;
                    if (status.read_last)
                    begin
                        cmd.accum_clr = 1'b1;
                        phase_next    = PH_LOAD;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ISC_ASSERT_IMP(a_out_free, cmd.out_load, !status.out_full, "result loaded into full output register")
    `ISC_ASSERT_IMP(a_div_idle, cmd.div_start, !status.div_busy, "divider started while busy")
    `ISC_ASSERT_NXT(a_load_seq, cmd.load_acc, state_reg == S_LOAD_UPD && phase_reg == PH_LOAD, "load word not followed by update")

endmodule

`default_nettype wire

### rtl/image_stripe_mean_corrector.sv
// Top level of the stripe mean corrector: configuration registers, controller
// and datapath. Depends on isc_pkg, isc_ctrl and isc_datapath.
`default_nettype none

// Loads an image in raster order, forms per-stripe and global Q16.16 means,
// then returns corrected Q23.8 pixels on read words. A load word does a stripe
// sum read-modify-write in the stripe memory. After the last load, a mean pass
// runs: per stripe a read and a check plus, for a non-empty stripe, an NW-bit
// division on the shared bit-serial divider (NW = 56 at default parameters),
// then one more for the global mean if any non-null pixel was loaded. A read
// word loads its result directly in subtract mode, for nulls or a zero stripe
// mean, else after a multiply and a division on the same divider. The result
// sits in the output register; a word is taken only while it is empty, so the
// next is taken no earlier than the cycle after the result leaves. After reset
// a clearing pass zeroes all max(MAX_ROWS, MAX_COLS) stripe entries; no word
// is taken until it ends, configuration writes are taken at any time.
module image_stripe_mean_corrector
    import isc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  isc_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output isc_out_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  divide_mode_reg;
    logic                  row_stripes_reg;
    logic [CFG_DATA_W-1:0] rows_in_use_reg;
    logic [CFG_DATA_W-1:0] cols_in_use_reg;
    isc_cmd_t              cmd;
    isc_status_t           status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divide_mode_reg <= 1'b0;
            row_stripes_reg <= 1'b0;
            rows_in_use_reg <= 9'd256;
            cols_in_use_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DIVIDE_MODE: divide_mode_reg <= cfg_data[0];
                CFG_ROW_STRIPES: row_stripes_reg <= cfg_data[0];
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data;
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
                default:         divide_mode_reg <= divide_mode_reg;
            endcase
        end
    end

    isc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_stall   (in_stall),
        .status     (status),
        .cmd        (cmd)
    );

    isc_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (in_data),
        .divide_mode (divide_mode_reg),
        .row_stripes (row_stripes_reg),
        .rows_in_use (rows_in_use_reg),
        .cols_in_use (cols_in_use_reg),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
